// File: hdl/point_triangle_projection_defines.svh
// Assertion macros for the checker file of this block.
`ifndef POINT_TRIANGLE_PROJECTION_DEFINES_SVH
`define POINT_TRIANGLE_PROJECTION_DEFINES_SVH

// Checked at every rising edge, reset included.
`define PTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked at every rising edge outside reset.
`define PTP_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: hdl/ptp_pkg.sv
`timescale 1ns / 1ps

package ptp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int COORD_FRAC      = 8;
  localparam int NORM_WIDTH      = 16;
  localparam int NORM_FRAC       = 14;
  // Fraction bits dropped when rounding normal * distance back to coordinates
  localparam int OFF_SHIFT       = 2 * NORM_FRAC;
  localparam int STAGES          = 8;

  typedef struct packed {
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

// File: hdl/point_triangle_projection.sv
`timescale 1ns / 1ps

// Point to triangle projection with an edge-normal inside test.
// Input channel (in_valid / in_ready) carries one query: point, three
// vertices (signed Q8.8 per component, x in the low bits) and a unit plane
// normal (signed Q2.14). Output channel (out_valid / out_ready) returns the
// saturated offset vector (point minus its projection onto the plane) and
// inside_res, set when the projection lies inside the triangle or on an edge.
// out_valid rises once the query has passed through all register stages and
// its result sits in the output register of stage 8.
// Throughput is one transaction per cycle while the output is not stalled; the
// eight register stages follow the multiplier chain plane distance, normal times
// distance, then the edge dot products, with at most one multiply layer per stage.
// Every stage carries a valid bit and a stage loads whenever it is empty or
// drains, so bubbles are squeezed out and in_ready stays high while the
// output register is empty or taken.
// When the receiver stalls the output holds, the pipeline fills up behind it
// and in_ready drops once every stage is full; nothing is lost or repeated.
// Synchronous reset empties all stages; the data registers are not reset.
module point_triangle_projection #(
  parameter int COORD_WIDTH = ptp_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [3*COORD_WIDTH-1:0]     query_point,
  input  logic [3*COORD_WIDTH-1:0]     vertex_a,
  input  logic [3*COORD_WIDTH-1:0]     vertex_b,
  input  logic [3*COORD_WIDTH-1:0]     vertex_c,
  input  logic [3*ptp_pkg::NORM_WIDTH-1:0] unit_normal,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3*COORD_WIDTH-1:0]     offset_vector,
  output logic                         inside_res
);
  import ptp_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int NW  = NORM_WIDTH;
  localparam int DW  = W + 1;          // coordinate difference
  localparam int PDW = DW + NW;        // difference times normal
  localparam int DSW = PDW + 2;        // plane distance
  localparam int CXW = PDW + 1;        // cross product component
  localparam int EW  = CXW - COORD_FRAC; // edge normal component
  localparam int ONW = DSW + NW;       // normal times distance
  localparam int OW  = ONW + 1 - OFF_SHIFT; // rounded offset
  localparam int QW  = OW + 1;         // projected point
  localparam int RW  = QW + 1;         // projected point minus edge start
  localparam int RPW = RW + EW;        // edge dot product term
  localparam int TW  = RPW + 2;        // edge dot product

  localparam logic signed [ONW:0] OFF_RND = (ONW + 1)'(1) <<< (OFF_SHIFT - 1);

  pipe_ctrl_t ctrl;

  ptp_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  assign in_ready  = ctrl.en[0];
  assign out_valid = ctrl.valid[STAGES-1];

  // Stage 1: unpack, point minus A, edge vectors
  logic signed [W-1:0]  s1_p   [3];
  logic signed [W-1:0]  s1_vtx [3][3];
  logic signed [NW-1:0] s1_n   [3];
  logic signed [DW-1:0] s1_diff[3];
  logic signed [DW-1:0] s1_ed  [3][3];

  logic signed [W-1:0] in_vtx [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_vtx[0][k] = $signed(vertex_a[k*W +: W]);
      in_vtx[1][k] = $signed(vertex_b[k*W +: W]);
      in_vtx[2][k] = $signed(vertex_c[k*W +: W]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      for (int k = 0; k < 3; k++) begin
        s1_p[k]    <= $signed(query_point[k*W +: W]);
        s1_n[k]    <= $signed(unit_normal[k*NW +: NW]);
        s1_diff[k] <= DW'($signed(query_point[k*W +: W])) - DW'(in_vtx[0][k]);
        for (int j = 0; j < 3; j++) begin
          s1_vtx[j][k] <= in_vtx[j][k];
          s1_ed[j][k]  <= DW'(in_vtx[(j+1)%3][k]) - DW'(in_vtx[j][k]);
        end
      end
    end
  end

  // Stage 2: distance products and cross product terms
  logic signed [W-1:0]   s2_p   [3];
  logic signed [W-1:0]   s2_vtx [3][3];
  logic signed [NW-1:0]  s2_n   [3];
  logic signed [PDW-1:0] s2_pdn [3];
  logic signed [PDW-1:0] s2_cpa [3][3];
  logic signed [PDW-1:0] s2_cpb [3][3];

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s2_p[k]   <= s1_p[k];
        s2_n[k]   <= s1_n[k];
        s2_pdn[k] <= PDW'(s1_diff[k]) * PDW'(s1_n[k]);
        for (int j = 0; j < 3; j++) begin
          s2_vtx[j][k] <= s1_vtx[j][k];
          s2_cpa[j][k] <= PDW'(s1_ed[j][(k+1)%3]) * PDW'(s1_n[(k+2)%3]);
          s2_cpb[j][k] <= PDW'(s1_ed[j][(k+2)%3]) * PDW'(s1_n[(k+1)%3]);
        end
      end
    end
  end

  // Stage 3: plane distance, edge normals floored to normal precision
  logic signed [W-1:0]   s3_p   [3];
  logic signed [W-1:0]   s3_vtx [3][3];
  logic signed [NW-1:0]  s3_n   [3];
  logic signed [DSW-1:0] s3_d;
  logic signed [EW-1:0]  s3_e   [3][3];

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      s3_d <= DSW'(s2_pdn[0]) + DSW'(s2_pdn[1]) + DSW'(s2_pdn[2]);
      for (int k = 0; k < 3; k++) begin
        s3_p[k] <= s2_p[k];
        s3_n[k] <= s2_n[k];
        for (int j = 0; j < 3; j++) begin
          s3_vtx[j][k] <= s2_vtx[j][k];
          s3_e[j][k]   <= EW'((CXW'(s2_cpa[j][k]) - CXW'(s2_cpb[j][k])) >>> COORD_FRAC);
        end
      end
    end
  end

  // Stage 4: normal times distance
  logic signed [W-1:0]   s4_p   [3];
  logic signed [W-1:0]   s4_vtx [3][3];
  logic signed [EW-1:0]  s4_e   [3][3];
  logic signed [ONW-1:0] s4_nd  [3];

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      for (int k = 0; k < 3; k++) begin
        s4_p[k]  <= s3_p[k];
        s4_nd[k] <= ONW'(s3_n[k]) * ONW'(s3_d);
        for (int j = 0; j < 3; j++) begin
          s4_vtx[j][k] <= s3_vtx[j][k];
          s4_e[j][k]   <= s3_e[j][k];
        end
      end
    end
  end

  // Stage 5: round half up to coordinate precision, project the point
  logic signed [ONW:0]  nd_rnd [3];
  logic signed [OW-1:0] off_c  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nd_rnd[k] = (ONW + 1)'(s4_nd[k]) + OFF_RND;
      off_c[k]  = OW'(nd_rnd[k] >>> OFF_SHIFT);
    end
  end

  logic signed [W-1:0]  s5_vtx [3][3];
  logic signed [EW-1:0] s5_e   [3][3];
  logic signed [OW-1:0] s5_off [3];
  logic signed [QW-1:0] s5_q   [3];

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      for (int k = 0; k < 3; k++) begin
        s5_off[k] <= off_c[k];
        s5_q[k]   <= QW'(s4_p[k]) - QW'(off_c[k]);
        for (int j = 0; j < 3; j++) begin
          s5_vtx[j][k] <= s4_vtx[j][k];
          s5_e[j][k]   <= s4_e[j][k];
        end
      end
    end
  end

  // Stage 6: projection relative to each edge start
  logic signed [EW-1:0] s6_e   [3][3];
  logic signed [RW-1:0] s6_rel [3][3];
  logic signed [OW-1:0] s6_off [3];

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      for (int k = 0; k < 3; k++) begin
        s6_off[k] <= s5_off[k];
        for (int j = 0; j < 3; j++) begin
          s6_e[j][k]   <= s5_e[j][k];
          s6_rel[j][k] <= RW'(s5_q[k]) - RW'(s5_vtx[j][k]);
        end
      end
    end
  end

  // Stage 7: edge dot product terms, offset saturation
  logic signed [W-1:0] sat_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s6_off[k][OW-1:W-1] == '0 || s6_off[k][OW-1:W-1] == '1) begin
        sat_c[k] = W'(s6_off[k]);
      end else if (s6_off[k][OW-1]) begin
        sat_c[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat_c[k] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  logic signed [RPW-1:0] s7_rp  [3][3];
  logic signed [W-1:0]   s7_off [3];

  always_ff @(posedge clk) begin
    if (ctrl.en[6]) begin
      for (int k = 0; k < 3; k++) begin
        s7_off[k] <= sat_c[k];
        for (int j = 0; j < 3; j++) begin
          s7_rp[j][k] <= RPW'(s6_rel[j][k]) * RPW'(s6_e[j][k]);
        end
      end
    end
  end

  // Stage 8: sum per edge, inside when no edge distance is positive
  logic signed [TW-1:0] edge_sum [3];
  logic [2:0]           edge_in;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      edge_sum[j] = TW'(s7_rp[j][0]) + TW'(s7_rp[j][1]) + TW'(s7_rp[j][2]);
      edge_in[j]  = edge_sum[j][TW-1] | (edge_sum[j] == '0);
    end
  end

  logic [3*W-1:0] s8_off;
  logic           s8_inside;

  always_ff @(posedge clk) begin
    if (ctrl.en[7]) begin
      for (int k = 0; k < 3; k++) begin
        s8_off[k*W +: W] <= s7_off[k];
      end
      s8_inside <= &edge_in;
    end
  end

  assign offset_vector = s8_off;
  assign inside_res    = s8_inside;

endmodule

// File: hdl/ptp_pipe_ctrl.sv
`timescale 1ns / 1ps

module ptp_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output ptp_pkg::pipe_ctrl_t ctrl
);
  import ptp_pkg::*;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] en;

  // A stage may load when it is empty or its contents move on this cycle
  always_comb begin
    en[STAGES-1] = ~valid[STAGES-1] | out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = ~valid[i] | en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign ctrl.en    = en;
  assign ctrl.valid = valid;

endmodule

// File: hdl/ptp_checker.sv
`timescale 1ns / 1ps
`include "point_triangle_projection_defines.svh"

module ptp_checker #(
  parameter int COORD_WIDTH = ptp_pkg::COORD_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [3*COORD_WIDTH-1:0]         offset_vector,
  input logic                             inside_res
);

  // Reset leaves no transaction in flight
  `PTP_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

  // A taken or empty output slot lets the whole pipeline advance
  `PTP_ASSERT_RUN(a_ready_on_drain, out_ready |-> in_ready, "input stalled while output drains")

  `PTP_ASSERT_RUN(a_ready_on_empty, !out_valid |-> in_ready, "input stalled with empty output")

  // Stalled result holds
  `PTP_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(offset_vector) && $stable(inside_res), "stalled result changed")

endmodule

bind point_triangle_projection ptp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ptp_checker (.*);
